// ===== rtl/actt_pkg.sv =====
// Shared types and constants for the aged connection token table.
package actt_pkg;

  localparam logic MODE_ISSUE = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  localparam logic [31:0] MAX_AGE_RESET = 32'd700;

  typedef struct packed {
    logic        mode;
    logic [31:0] tick_now;
    logic [31:0] fresh_value;
    logic [31:0] presented_value;
    logic [47:0] source_addr;
  } req_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic used;
  } cell_stat_t;

endpackage

// ===== rtl/actt_cell.sv =====
// One table entry with its slice of the search chain.
module actt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         max_age_i,
  input  actt_pkg::req_t      req_i,
  input  logic                tok_i,
  output logic                tok_o,
  output actt_pkg::cell_stat_t stat_o
);
  import actt_pkg::*;

  logic        tok_q;
  logic        used_q, used_d;
  logic [31:0] value_q, value_d;
  logic [31:0] tick_q, tick_d;
  logic [47:0] addr_q, addr_d;
  logic [31:0] age;
  logic        expired, match, done, hit;

  // Modular age; unsigned compare against the configured limit.
  assign age     = req_i.tick_now - tick_q;
  assign expired = age >= max_age_i;
  assign match   = (value_q == req_i.presented_value) &&
                   (addr_q == req_i.source_addr) && !expired;

  always_comb begin
    used_d  = used_q;
    value_d = value_q;
    tick_d  = tick_q;
    addr_d  = addr_q;
    done    = 1'b0;
    hit     = 1'b0;
    if (tok_q) begin
      if (req_i.mode == MODE_ISSUE) begin
        // A free cell is the append slot, since occupied cells form a prefix.
        done = !used_q || expired;
        hit  = done;
        if (done) begin
          used_d  = 1'b1;
          value_d = req_i.fresh_value;
          tick_d  = req_i.tick_now;
          addr_d  = req_i.source_addr;
        end
      end else begin
        done = !used_q || match;
        hit  = used_q && match;
        if (hit) begin
          tick_d = req_i.tick_now;
        end
      end
    end
  end

  assign tok_o       = tok_q && !done;
  assign stat_o.done = done;
  assign stat_o.hit  = hit;
  assign stat_o.used = used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      used_q <= 1'b0;
    end else begin
      tok_q  <= tok_i;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    tick_q  <= tick_d;
    addr_q  <= addr_d;
  end

endmodule

// ===== rtl/aged_connect_token_table_top.sv =====
// Top level of the aged connection token table: request register, cell chain, result staging.
//
// Usage: one input beat carries a request. mode 0 issues fresh_value as a new
// token for source_addr at tick_now, mode 1 checks presented_value against the
// table. Every request returns exactly one output beat: issued_value on a
// successful issue, accepted on a matching check, table_full when an issue
// finds no expired and no free entry.
// The request walks a chain of TABLE_DEPTH cells, one cell per cycle, and stops
// at the first cell that decides it. From its input beat an item passes the request
// register, the cells up to the one that decides it, the staging register and the
// output register; the chain length bounds that path. Only one request is in the
// chain at a time; in_stall_o stays high until its result has moved on to the output
// register, so a new input beat comes no earlier than the previous output beat: the
// block takes no new request before the last one is through. While out_stall_i holds
// the output register, a finished result waits in a staging register.
// max_age_ticks is to be written through cfg_we_i / cfg_wdata_i only while the block is
// idle; the block itself does not enforce this. Reset empties the table and sets
// max_age_ticks to 700; no clearing pass is needed.
module aged_connect_token_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] tick_now_i,
  input  logic [31:0] fresh_value_i,
  input  logic [31:0] presented_value_i,
  input  logic [47:0] source_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] issued_value_o,
  output logic        accepted_o,
  output logic        table_full_o
);
  import actt_pkg::*;

  logic [31:0]      max_age_q;
  req_t             req_q;
  logic             busy_q;
  logic             in_accept;
  logic [TABLE_DEPTH:0]   tok;
  logic [TABLE_DEPTH-1:0] done_vec, hit_vec, used_vec;
  cell_stat_t       stat [TABLE_DEPTH];
  logic             done_any, hit_any;

  logic             pend_q;
  logic [31:0]      pend_issued_q;
  logic             pend_accepted_q, pend_full_q;
  logic             out_valid_q;
  logic [31:0]      out_issued_q;
  logic             out_accepted_q, out_full_q;
  logic             out_free;

  assign in_stall_o = busy_q || pend_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign tok[0]     = in_accept;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    actt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .max_age_i (max_age_q),
      .req_i     (req_q),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1]),
      .stat_o    (stat[k])
    );
    assign done_vec[k] = stat[k].done;
    assign hit_vec[k]  = stat[k].hit;
    assign used_vec[k] = stat[k].used;
  end

  // A beat leaving the last cell means the whole table was passed without a decision.
  assign done_any = (|done_vec) || tok[TABLE_DEPTH];
  assign hit_any  = |hit_vec;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q   <= MAX_AGE_RESET;
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (done_any) begin
        busy_q <= 1'b0;
      end
      if (done_any) begin
        pend_q <= 1'b1;
      end else if (pend_q && out_free) begin
        pend_q <= 1'b0;
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.mode            <= mode_i;
      req_q.tick_now        <= tick_now_i;
      req_q.fresh_value     <= fresh_value_i;
      req_q.presented_value <= presented_value_i;
      req_q.source_addr     <= source_addr_i;
    end
    if (done_any) begin
      pend_issued_q   <= (req_q.mode == MODE_ISSUE && hit_any) ? req_q.fresh_value : 32'd0;
      pend_accepted_q <= (req_q.mode == MODE_CHECK) && hit_any;
      pend_full_q     <= (req_q.mode == MODE_ISSUE) && !hit_any;
    end
    if (pend_q && out_free) begin
      out_issued_q   <= pend_issued_q;
      out_accepted_q <= pend_accepted_q;
      out_full_q     <= pend_full_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign issued_value_o = out_issued_q;
  assign accepted_o     = out_accepted_q;
  assign table_full_o   = out_full_q;

  // At most one request beat travels the chain.
  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok[TABLE_DEPTH:1]))
    else $error("more than one request in the cell chain");

  // Occupied cells always form a prefix of the table.
  a_used_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_vec & ~{used_vec[TABLE_DEPTH-2:0], 1'b1}) == '0)
    else $error("occupied entries are not contiguous");

  // A decision only comes while a request is in flight.
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_any |-> busy_q && !pend_q)
    else $error("chain finished with no request in flight");

  // Every result sets exactly one kind of outcome at most.
  a_one_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $onehot0({pend_accepted_q, pend_full_q}))
    else $error("result flags both accepted and full");

endmodule
